FILE: rtl/msp_pkg.sv
// Package for the memory size suffix parser.
// Holds the shared store size codes and the record passed from parse to output stage.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned SIZE_W  = 4;

   // destination sizes in bytes
   localparam logic [SIZE_W-1:0] SIZE_B1    = 4'd1;
   localparam logic [SIZE_W-1:0] SIZE_B2    = 4'd2;
   localparam logic [SIZE_W-1:0] SIZE_B4    = 4'd4;
   localparam logic [SIZE_W-1:0] SIZE_B8    = 4'd8;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_B8;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_SIZE = 1'b1;

   // final sums of one string, handed to the output stage
   typedef struct packed {
      logic [VALUE_W-1:0] total;
      logic [VALUE_W-1:0] pending;
   } fin_type;

endpackage

`default_nettype wire

FILE: rtl/msp_step.sv
// Per-character parse step: holds the parse state and the finished-string register.
// Depends on msp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msp_step
   import msp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire logic [7:0]  in_ch,
   input  wire logic        in_last,
   output logic             in_ready,
   output logic             fin_valid,
   output fin_type          fin_data,
   input  wire logic        fin_ready
);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5a;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7a;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UK    = 8'h4b;
   localparam logic [7:0] CH_LK    = 8'h6b;
   localparam logic [7:0] CH_UM    = 8'h4d;
   localparam logic [7:0] CH_LM    = 8'h6d;
   localparam logic [7:0] CH_UG    = 8'h47;
   localparam logic [7:0] CH_LG    = 8'h67;
   localparam logic [7:0] CH_UT    = 8'h54;
   localparam logic [7:0] CH_LT    = 8'h74;
   localparam logic [7:0] CH_UP    = 8'h50;
   localparam logic [7:0] CH_LP    = 8'h70;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_SAT    = 2'd2;

   function automatic logic [5:0] digit_of(input logic [7:0] c);
      logic [5:0] d;
      d = 6'd0;
      if (c >= CH_0 && c <= CH_9) begin
         d = 6'(c - CH_0);
      end else if (c >= CH_LA && c <= CH_LZ) begin
         d = 6'(c - CH_LA) + 6'd10;
      end else if (c >= CH_UA && c <= CH_UZ) begin
         d = 6'(c - CH_UA) + 6'd10;
      end
      return d;
   endfunction

   logic [VALUE_W-1:0] total_ff, total_in;
   logic [VALUE_W-1:0] pending_ff, pending_in;
   logic               hex_ff, hex_in;
   logic [1:0]         pos_ff, pos_in;
   logic               ended_ff, ended_in;
   logic               fin_valid_ff, fin_valid_in;
   fin_type            fin_ff, fin_in;

   logic               take;
   logic               is_suffix;
   logic [5:0]         shift;
   logic [VALUE_W-1:0] step_total, step_pending;
   logic               step_hex, step_ended;
   logic [1:0]         step_pos;

   // a last character needs room in the finished-string register
   assign in_ready = !in_last || !fin_valid_ff || fin_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      is_suffix = 1'b1;
      shift     = 6'd0;
      unique case (in_ch)
         CH_UK, CH_LK: shift = 6'd10;
         CH_UM, CH_LM: shift = 6'd20;
         CH_UG, CH_LG: shift = 6'd30;
         CH_UT, CH_LT: shift = 6'd40;
         CH_UP, CH_LP: shift = 6'd50;
         CH_UB, CH_LB: shift = 6'd0;
         default:      is_suffix = 1'b0;
      endcase
   end

   always_comb begin
      step_total   = total_ff;
      step_pending = pending_ff;
      step_hex     = hex_ff;
      step_pos     = pos_ff;
      step_ended   = ended_ff;
      if (!ended_ff) begin
         if (in_ch == CH_NUL) begin
            step_ended = 1'b1;
         end else begin
            step_pos = (pos_ff == POS_SAT) ? POS_SAT : pos_ff + 2'd1;
            if (pos_ff == POS_SECOND && (in_ch == CH_LX || in_ch == CH_UX)
                && pending_ff == '0) begin
               step_hex = 1'b1;
            end else if (is_suffix) begin
               step_total   = total_ff + (pending_ff << shift);
               step_pending = '0;
            end else if (hex_ff) begin
               step_pending = (pending_ff << 4) + VALUE_W'(digit_of(in_ch));
            end else begin
               step_pending = (pending_ff << 3) + (pending_ff << 1)
                              + VALUE_W'(digit_of(in_ch));
            end
         end
      end
   end

   always_comb begin
      total_in     = total_ff;
      pending_in   = pending_ff;
      hex_in       = hex_ff;
      pos_in       = pos_ff;
      ended_in     = ended_ff;
      fin_in       = fin_ff;
      fin_valid_in = fin_valid_ff && !fin_ready;
      if (take) begin
         if (in_last) begin
            total_in      = '0;
            pending_in    = '0;
            hex_in        = 1'b0;
            pos_in        = POS_FIRST;
            ended_in      = 1'b0;
            fin_in.total   = step_total;
            fin_in.pending = step_pending;
            fin_valid_in  = 1'b1;
         end else begin
            total_in   = step_total;
            pending_in = step_pending;
            hex_in     = step_hex;
            pos_in     = step_pos;
            ended_in   = step_ended;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         pending_ff   <= '0;
         hex_ff       <= 1'b0;
         pos_ff       <= POS_FIRST;
         ended_ff     <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         pending_ff   <= pending_in;
         hex_ff       <= hex_in;
         pos_ff       <= pos_in;
         ended_ff     <= ended_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
   end

   assign fin_valid = fin_valid_ff;
   assign fin_data  = fin_ff;

   // string end wipes the parse state
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      take && in_last |=> total_ff == '0 && pending_ff == '0 && pos_ff == POS_FIRST
                          && !hex_ff && !ended_ff)
      else $error("parse state not cleared after last character");

   // hex mode only comes from the second character
   a_hex_pos: assert property (@(posedge clock) disable iff (reset)
      hex_ff |-> pos_ff == POS_SAT)
      else $error("hex mode set with character position below two");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff && !fin_ready |=> fin_valid_ff && $stable(fin_ff))
      else $error("finished string dropped while stalled");

endmodule

`default_nettype wire

FILE: rtl/msp_fit.sv
// Output stage: adds the final sums, fits them to the store size, holds the result.
// Depends on msp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msp_fit
   import msp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [SIZE_W-1:0]   store_size,
   input  wire logic                fin_valid,
   input  wire fin_type             fin_data,
   output logic                     fin_ready,
   output logic                     out_valid,
   output logic signed [VALUE_W-1:0] out_value,
   output logic                     out_status,
   input  wire logic                out_ready
);

   logic                      out_valid_ff, out_valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      status_ff, status_in;
   logic [VALUE_W-1:0]        sum;
   logic                      load;

   assign fin_ready = !out_valid_ff || out_ready;
   assign load      = fin_valid && fin_ready;
   assign sum       = fin_data.total + fin_data.pending;

   always_comb begin
      value_in  = value_ff;
      status_in = status_ff;
      if (load) begin
         status_in = STATUS_OK;
         unique case (store_size)
            SIZE_B1: value_in = {{(VALUE_W-8){sum[7]}}, sum[7:0]};
            SIZE_B2: value_in = {{(VALUE_W-16){sum[15]}}, sum[15:0]};
            SIZE_B4: value_in = {{(VALUE_W-32){sum[31]}}, sum[31:0]};
            SIZE_B8: value_in = sum;
            default: begin
               value_in  = '0;
               status_in = STATUS_BAD_SIZE;
            end
         endcase
      end
   end

   assign out_valid_in = load || (out_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_value  = value_ff;
   assign out_status = status_ff;

   a_bad_size_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && status_ff == STATUS_BAD_SIZE |-> value_ff == '0)
      else $error("bad store size result carries a nonzero value");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready |=> out_valid_ff && $stable(value_ff)
                                     && $stable(status_ff))
      else $error("held result overwritten");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |=> out_valid_ff)
      else $error("loaded result not shown");

endmodule

`default_nettype wire

FILE: rtl/memory_size_suffix_parser.sv
// Top level of the memory size suffix parser: input register, parse step, output stage.
// Depends on msp_pkg, msp_step and msp_fit.
`timescale 1ns / 1ps
`default_nettype none

// Memory size suffix parser. Feed the size string one character per transfer on
// req_ (req_ch, with req_last_char high on the final character); one result per
// string comes out on rsp_ as rsp_value and rsp_status. Digits accumulate in base
// 10, or base 16 when the second character is x/X after a zero; suffixes k, m, g,
// t, p and b (either case) scale the pending number by 2^10..2^50 or 1 and add it
// to the total; a NUL character ends the text and the rest of the string is
// ignored. The result is total plus pending, truncated to csr_store_size_bytes
// bytes and sign-extended to 64 bits; a size other than 1, 2, 4 or 8 gives status
// 1 and value 0. The block takes one character every clock unless the result
// path stalls; the parse state loop (one multiply by 10 or 16 plus add per
// character) feeds the parse registers straight back. A result passes the input
// register, the parse step into the finished-string register, then the output
// register to rsp_valid. Write csr_ only while idle; reset sets the store size to 8.

module memory_size_suffix_parser
   import msp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_ch,
   input  wire logic                req_last_char,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                     rsp_status,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [SIZE_W-1:0]   csr_store_size_bytes
);

   // configuration register: always ready, written on transfer
   logic [SIZE_W-1:0] size_ff, size_in;

   // input register
   logic        a_valid_ff, a_valid_in;
   logic [7:0]  a_ch_ff, a_ch_in;
   logic        a_last_ff, a_last_in;
   logic        step_ready;
   logic        a_fire;

   fin_type     fin_data;
   logic        fin_valid;
   logic        fin_ready;

   assign csr_ready = 1'b1;
   assign size_in   = (csr_valid && csr_ready) ? csr_store_size_bytes : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // advance the input register whenever the parse step takes its character
   assign a_fire     = a_valid_ff && step_ready;
   assign req_ready  = !a_valid_ff || step_ready;
   assign a_valid_in = (req_valid && req_ready) || (a_valid_ff && !a_fire);
   assign a_ch_in    = (req_valid && req_ready) ? req_ch : a_ch_ff;
   assign a_last_in  = (req_valid && req_ready) ? req_last_char : a_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ch_ff   <= a_ch_in;
      a_last_ff <= a_last_in;
   end

   msp_step u_step (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_ch     (a_ch_ff),
      .in_last   (a_last_ff),
      .in_ready  (step_ready),
      .fin_valid (fin_valid),
      .fin_data  (fin_data),
      .fin_ready (fin_ready)
   );

   msp_fit u_fit (
      .clock      (clock),
      .reset      (reset),
      .store_size (size_ff),
      .fin_valid  (fin_valid),
      .fin_data   (fin_data),
      .fin_ready  (fin_ready),
      .out_valid  (rsp_valid),
      .out_value  (rsp_value),
      .out_status (rsp_status),
      .out_ready  (rsp_ready)
   );

   // a stalled character stays put until the parse step takes it
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !a_fire |=> a_valid_ff && $stable(a_ch_ff) && $stable(a_last_ff))
      else $error("input register lost a stalled character");

endmodule

`default_nettype wire

FILE: dv/size_parse_checker.sv
// Checker for the memory size suffix parser: watches the req_, rsp_ and csr_ channels.
// Predicts each result from accepted characters and compares it with the rsp_ transfers.
// Depends on msp_pkg.
`timescale 1ns / 1ps

module size_parse_checker
   import msp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_ch,
   input  logic               req_last_char,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [VALUE_W-1:0] rsp_value,
   input  logic               rsp_status,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [SIZE_W-1:0]  csr_store_size_bytes,
   output int unsigned        awaited_count,
   output int unsigned        fail_count
);

   localparam logic [7:0] NUL_CHAR   = 8'h00;
   localparam int unsigned PRINT_MAX = 40;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               status;
   } size_result_type;

   logic [VALUE_W-1:0] total_bytes;
   logic [VALUE_W-1:0] pending_num;
   logic               hex_base;
   logic [1:0]         char_pos;
   logic               text_done;
   logic [SIZE_W-1:0]  store_size;
   size_result_type    awaited_sizes[$];
   size_result_type    oldest;
   int unsigned        mismatch_total = 0;

   task report_mismatch(input string msg);
      mismatch_total++;
      if (mismatch_total <= PRINT_MAX)
         $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   task clear_parse_state();
      total_bytes = '0;
      pending_num = '0;
      hex_base    = 1'b0;
      char_pos    = 2'd0;
      text_done   = 1'b0;
   endtask

   // Advance the parse by one character; queue the size on the last one.
   task parse_size_char(input logic [7:0] c, input logic last);
      logic [1:0]         pos;
      logic [5:0]         shift;
      logic               is_suffix;
      logic [VALUE_W-1:0] digit;
      logic [VALUE_W-1:0] sum;
      size_result_type    res;
      if (!text_done) begin
         if (c == NUL_CHAR) begin
            text_done = 1'b1;
         end else begin
            pos = char_pos;
            if (char_pos < 2'd2)
               char_pos = char_pos + 2'd1;
            if (pos == 2'd1 && (c == "x" || c == "X") && pending_num == '0) begin
               hex_base = 1'b1;
            end else begin
               is_suffix = 1'b1;
               shift     = 6'd0;
               case (c)
                  "k", "K": shift = 6'd10;
                  "m", "M": shift = 6'd20;
                  "g", "G": shift = 6'd30;
                  "t", "T": shift = 6'd40;
                  "p", "P": shift = 6'd50;
                  "b", "B": shift = 6'd0;
                  default:  is_suffix = 1'b0;
               endcase
               if (is_suffix) begin
                  total_bytes = total_bytes + (pending_num << shift);
                  pending_num = '0;
               end else begin
                  if (c >= "0" && c <= "9")
                     digit = VALUE_W'(c - "0");
                  else if (c >= "a" && c <= "z")
                     digit = VALUE_W'(c - "a") + 64'd10;
                  else if (c >= "A" && c <= "Z")
                     digit = VALUE_W'(c - "A") + 64'd10;
                  else
                     digit = '0;
                  pending_num = pending_num * (hex_base ? 64'd16 : 64'd10) + digit;
               end
            end
         end
      end
      if (last) begin
         sum        = total_bytes + pending_num;
         res.status = STATUS_OK;
         case (store_size)
            SIZE_B1: res.value = {{56{sum[7]}}, sum[7:0]};
            SIZE_B2: res.value = {{48{sum[15]}}, sum[15:0]};
            SIZE_B4: res.value = {{32{sum[31]}}, sum[31:0]};
            SIZE_B8: res.value = sum;
            default: begin
               res.value  = '0;
               res.status = STATUS_BAD_SIZE;
            end
         endcase
         awaited_sizes.push_back(res);
         clear_parse_state();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse_state();
         store_size = SIZE_RESET;
         awaited_sizes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_sizes.size() == 0) begin
               report_mismatch($sformatf("unexpected result value %h status %0b",
                                         rsp_value, rsp_status));
            end else begin
               oldest = awaited_sizes.pop_front();
               if (rsp_value !== oldest.value)
                  report_mismatch($sformatf("value %h, predicted %h",
                                            rsp_value, oldest.value));
               if (rsp_status !== oldest.status)
                  report_mismatch($sformatf("status %0b, predicted %0b",
                                            rsp_status, oldest.status));
            end
         end
         if (csr_valid && csr_ready)
            store_size = csr_store_size_bytes;
         if (req_valid && req_ready)
            parse_size_char(req_ch, req_last_char);
      end
      awaited_count <= awaited_sizes.size();
      fail_count    <= mismatch_total;
   end

endmodule

FILE: dv/testbench.sv
// Top of the memory size suffix parser testbench: clock, reset, stimulus and verdict.
// Depends on msp_pkg, memory_size_suffix_parser and size_parse_checker.
`timescale 1ns / 1ps

module testbench
   import msp_pkg::*;
();

   localparam logic [7:0] NUL_CHAR     = 8'h00;
   localparam int unsigned RANDOM_ITEMS = 1400;
   localparam int unsigned PLAN_STEPS   = 12;
   // slack for the pipeline to settle after the last result
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam string HEX_CHARS    = "0123456789abcdefABCDEF";
   localparam string SUFFIX_CHARS = "kKmMgGtTpPbB";

   // store sizes walked through during the random part, invalid ones included
   localparam logic [SIZE_W-1:0] SIZE_PLAN [PLAN_STEPS] = '{
      SIZE_B1, SIZE_B2, SIZE_B4, SIZE_B8, 4'd0, 4'd15,
      4'd3, SIZE_B1, SIZE_B4, 4'd9, SIZE_B2, SIZE_B8
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [7:0]          req_ch;
   logic                req_last_char;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [VALUE_W-1:0]  rsp_value;
   logic                rsp_status;
   logic                csr_valid;
   logic                csr_ready;
   logic [SIZE_W-1:0]   csr_store_size_bytes;
   int unsigned         awaited_count;
   int unsigned         fail_count;

   int unsigned         send_idle_pct = 0;
   int unsigned         recv_idle_pct = 0;
   int unsigned         chars_sent    = 0;
   logic [7:0]          text_q[$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   memory_size_suffix_parser dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_ch               (req_ch),
      .req_last_char        (req_last_char),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_value            (rsp_value),
      .rsp_status           (rsp_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_store_size_bytes (csr_store_size_bytes)
   );

   size_parse_checker size_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_ch               (req_ch),
      .req_last_char        (req_last_char),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_value            (rsp_value),
      .rsp_status           (rsp_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_store_size_bytes (csr_store_size_bytes),
      .awaited_count        (awaited_count),
      .fail_count           (fail_count)
   );

   // Receiver: stall at random at the current idle rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Offer one character, idling first at the sender's rate; return once the
   // transfer has happened. Valid stays high so a following call can reuse it.
   task send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_ch        <= c;
      req_last_char <= last;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
   endtask

   // Send the whole text buffer, marking the final character as last.
   task send_text();
      for (int i = 0; i < text_q.size(); i++)
         send_char(text_q[i], i == text_q.size() - 1);
   endtask

   task load_string(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++)
         text_q.push_back(s[i]);
   endtask

   // Drop valid, hold until every predicted result has been seen, then let
   // the pipeline settle.
   task wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Change the store size only while the block is idle.
   task write_store_size(input logic [SIZE_W-1:0] size_bytes);
      wait_for_drain();
      csr_valid            <= 1'b1;
      csr_store_size_bytes <= size_bytes;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed size strings (optional 0x prefix, digit groups with
   // suffixes), some of them spoiled, plus raw byte noise.
   task send_random_strings(input int unsigned budget);
      int unsigned start;
      int unsigned ndig;
      bit          hex;
      start = chars_sent;
      while (chars_sent - start < budget) begin
         text_q.delete();
         if ($urandom_range(99) < 80) begin
            hex = ($urandom_range(99) < 35);
            if (hex) begin
               text_q.push_back("0");
               text_q.push_back($urandom_range(1) ? "x" : "X");
            end
            repeat ($urandom_range(1, 3)) begin
               // mostly short groups; long ones may wrap the 64-bit sum
               ndig = ($urandom_range(9) == 0) ? $urandom_range(8, 22) : $urandom_range(1, 4);
               repeat (ndig)
                  text_q.push_back(hex ? HEX_CHARS[$urandom_range(21)]
                                       : HEX_CHARS[$urandom_range(9)]);
               if ($urandom_range(99) < 70)
                  text_q.push_back(SUFFIX_CHARS[$urandom_range(11)]);
            end
            if ($urandom_range(99) < 10)
               text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(99) < 5)
               text_q[$urandom_range(text_q.size() - 1)] = NUL_CHAR;
         end else begin
            repeat ($urandom_range(1, 8))
               text_q.push_back(8'($urandom_range(255)));
         end
         send_text();
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_ch               = '0;
      req_last_char        = 1'b0;
      rsp_ready            = 1'b0;
      csr_valid            = 1'b0;
      csr_store_size_bytes = SIZE_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      recv_idle_pct = 58;

      // Directed strings at the reset store size of eight bytes.
      load_string("12k");   send_text();
      load_string("0XfFM"); send_text();
      load_string("7");     send_text();
      // NUL ends the text; trailing letters are ignored
      load_string("3-zz");  text_q[1] = NUL_CHAR; send_text();
      load_string("-");     text_q[0] = NUL_CHAR; send_text();
      // high byte counts as digit zero
      load_string("9-T");   text_q[1] = 8'hFF; send_text();
      // x after a nonzero digit is just the letter value 33
      load_string("1x5");   send_text();
      load_string("Zb");    send_text();
      load_string("2g");    text_q[0] = 8'h80; send_text();
      load_string("4P");    send_text();

      // Random part: walk the size plan under three idle regimes.
      for (int step = 0; step < PLAN_STEPS; step++) begin
         if (step == PLAN_STEPS / 3) begin
            send_idle_pct = 58;
            recv_idle_pct = 35;
         end
         if (step == 2 * PLAN_STEPS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_store_size(SIZE_PLAN[step]);
         send_random_strings(RANDOM_ITEMS / PLAN_STEPS);
      end

      wait_for_drain();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/msp_pkg.sv
rtl/msp_step.sv
rtl/msp_fit.sv
rtl/memory_size_suffix_parser.sv
dv/size_parse_checker.sv
dv/testbench.sv
